// File: rtl/core/i2cxc_pkg.sv
// ----------------------------------------------------------------------------
// i2cxc_pkg
// Shared types and constants for the XOR-checked I2C slave command block.
// ----------------------------------------------------------------------------
package i2cxc_pkg;

  // Bus event codes
  typedef enum logic [2:0] {
    MODE_WR_ADDR  = 3'd0,
    MODE_DATA     = 3'd1,
    MODE_STOP     = 3'd2,
    MODE_RD_ADDR  = 3'd3,
    MODE_TX_ACK   = 3'd4,
    MODE_GEN_CALL = 3'd5,
    MODE_BUS_ERR  = 3'd6,
    MODE_OTHER    = 3'd7
  } mode_e;

  // Configuration register indexes
  localparam logic CFG_NODE_ADDR = 1'b0;
  localparam logic CFG_PING_CODE = 1'b1;

  localparam int unsigned  DEFAULT_STORE_DEPTH = 32;
  localparam logic [6:0]   NODE_ADDR_RST       = 7'd104;
  localparam logic [7:0]   PING_CODE_RST       = 8'd0;
  localparam logic [7:0]   FILL_BYTE           = 8'hFF;
  localparam logic [1:0]   FULL_REPLY          = 2'd2;

  // Item as it leaves the front stage, waiting for the store read data
  typedef struct packed {
    mode_e      mode;
    logic       stored;      // data byte went into the store
    logic       pop;         // stop with a byte to pop
    logic       fresh;       // stop while addressed
    logic [7:0] rx_byte;
    logic [5:0] length;      // count after pop, low six bits
    logic [7:0] first_byte;  // shadow of store entry zero
  } s1_t;

endpackage

// File: rtl/core/i2cxc_store.sv
// ----------------------------------------------------------------------------
// i2cxc_store
// Command byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module i2cxc_store import i2cxc_pkg::*; #(
  parameter int unsigned STORE_DEPTH = DEFAULT_STORE_DEPTH,
  localparam int unsigned AddrW = $clog2(STORE_DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem_q [STORE_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/i2cxc_front.sv
// ----------------------------------------------------------------------------
// i2cxc_front
// Front stage: byte count, open/addressed flags, store write and pop address.
// ----------------------------------------------------------------------------
module i2cxc_front import i2cxc_pkg::*; #(
  parameter int unsigned STORE_DEPTH = DEFAULT_STORE_DEPTH,
  localparam int unsigned AddrW = $clog2(STORE_DEPTH),
  localparam int unsigned CntW  = $clog2(STORE_DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             acc_i,
  input  logic [2:0]       mode_i,
  input  logic [7:0]       rx_byte_i,
  input  logic             adv_i,
  output logic             s1_valid_o,
  output s1_t              s1_o,
  output logic             mem_we_o,
  output logic [AddrW-1:0] mem_waddr_o,
  output logic             mem_re_o,
  output logic [AddrW-1:0] mem_raddr_o
);

  localparam logic [CntW-1:0] DepthC = CntW'(STORE_DEPTH);
  localparam logic [CntW-1:0] OneC   = CntW'(1);

  logic [CntW-1:0] cnt_q, cnt_d, cnt_dec;
  logic            open_q, open_d;
  logic            addr_q, addr_d;
  logic [7:0]      first_q, first_d;
  logic            s1_valid_q;
  s1_t             s1_q, s1_d;
  logic [CntW+5:0] len_wide;
  mode_e           mode;

  assign mode     = mode_e'(mode_i);
  assign cnt_dec  = cnt_q - OneC;
  assign len_wide = {6'b0, cnt_dec};

  always_comb begin
    cnt_d       = cnt_q;
    open_d      = open_q;
    addr_d      = addr_q;
    first_d     = first_q;
    mem_we_o    = 1'b0;
    mem_re_o    = 1'b0;
    mem_waddr_o = cnt_q[AddrW-1:0];
    mem_raddr_o = cnt_dec[AddrW-1:0];
    s1_d            = '0;
    s1_d.mode       = mode;
    s1_d.rx_byte    = rx_byte_i;
    s1_d.first_byte = first_q;
    unique case (mode)
      MODE_WR_ADDR: begin
        cnt_d  = '0;
        open_d = 1'b1;
        addr_d = 1'b1;
      end
      MODE_DATA: begin
        if (cnt_q == DepthC) begin
          open_d = 1'b0;
        end else if (open_q) begin
          mem_we_o  = acc_i;
          cnt_d     = cnt_q + OneC;
          s1_d.stored = 1'b1;
          if (cnt_q == '0) begin
            first_d = rx_byte_i;
          end
        end
      end
      MODE_STOP: begin
        if (addr_q) begin
          s1_d.fresh = 1'b1;
          if (cnt_q != '0) begin
            cnt_d       = cnt_dec;
            mem_re_o    = acc_i;
            s1_d.pop    = 1'b1;
            s1_d.length = len_wide[5:0];
          end
        end
      end
      MODE_GEN_CALL: addr_d = 1'b0;
      MODE_RD_ADDR, MODE_TX_ACK, MODE_BUS_ERR, MODE_OTHER: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      open_q     <= 1'b0;
      addr_q     <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      if (acc_i) begin
        cnt_q      <= cnt_d;
        open_q     <= open_d;
        addr_q     <= addr_d;
        s1_valid_q <= 1'b1;
      end else if (adv_i) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      first_q <= first_d;
      s1_q    <= s1_d;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_o       = s1_q;

endmodule

// File: rtl/core/i2cxc_reply.sv
// ----------------------------------------------------------------------------
// i2cxc_reply
// Back stage: running XOR, checksum check, reply sequencing, output register.
// ----------------------------------------------------------------------------
module i2cxc_reply import i2cxc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s1_valid_i,
  input  s1_t        s1_i,
  input  logic [7:0] rdata_i,
  input  logic [6:0] node_address_i,
  input  logic [7:0] ping_code_i,
  input  logic       out_stall_i,
  output logic       adv_o,
  output logic       out_valid_o,
  output logic [7:0] tx_byte_o,
  output logic       tx_valid_o,
  output logic       command_fresh_o,
  output logic       checksum_ok_o,
  output logic [5:0] command_length_o,
  output logic       sync_pulse_o,
  output logic       bus_reset_o
);

  logic [7:0] xor_q, xor_d;
  logic [7:0] check_q, check_d;
  logic [1:0] rlen_q, rlen_d;
  logic [1:0] sidx_q, sidx_d;
  logic       out_valid_q;

  logic [7:0] xor_pop, tx_byte_d;
  logic [1:0] idx_base;
  logic       have_byte, ok_d, tx_valid_d, sync_d, busrst_d;

  assign adv_o = s1_valid_i && (!out_valid_q || !out_stall_i);

  assign xor_pop   = xor_q ^ rdata_i;
  assign idx_base  = (s1_i.mode == MODE_RD_ADDR) ? 2'd0 : sidx_q;
  assign have_byte = idx_base < rlen_q;

  always_comb begin
    xor_d      = xor_q;
    check_d    = check_q;
    rlen_d     = rlen_q;
    sidx_d     = sidx_q;
    ok_d       = 1'b0;
    tx_byte_d  = 8'd0;
    tx_valid_d = 1'b0;
    sync_d     = 1'b0;
    busrst_d   = 1'b0;
    unique case (s1_i.mode)
      MODE_WR_ADDR: xor_d = {1'b0, node_address_i};
      MODE_DATA: begin
        if (s1_i.stored) begin
          xor_d = xor_q ^ s1_i.rx_byte;
        end
      end
      MODE_STOP: begin
        if (s1_i.pop) begin
          xor_d = xor_pop;
          if (rdata_i == xor_pop) begin
            ok_d    = 1'b1;
            check_d = xor_pop + {7'd0, s1_i.first_byte == ping_code_i};
            rlen_d  = FULL_REPLY;
          end else begin
            rlen_d  = 2'd0;
          end
        end else if (s1_i.fresh) begin
          rlen_d = 2'd0;
        end
      end
      MODE_RD_ADDR, MODE_TX_ACK: begin
        tx_valid_d = 1'b1;
        sidx_d     = idx_base;
        if (have_byte) begin
          tx_byte_d = (idx_base == 2'd0) ? {1'b0, node_address_i} : check_q;
          sidx_d    = idx_base + 2'd1;
        end else begin
          tx_byte_d = FILL_BYTE;
        end
      end
      MODE_GEN_CALL: sync_d   = 1'b1;
      MODE_BUS_ERR:  busrst_d = 1'b1;
      MODE_OTHER: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xor_q       <= '0;
      check_q     <= '0;
      rlen_q      <= '0;
      sidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv_o) begin
        xor_q       <= xor_d;
        check_q     <= check_d;
        rlen_q      <= rlen_d;
        sidx_q      <= sidx_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      tx_byte_o        <= tx_byte_d;
      tx_valid_o       <= tx_valid_d;
      command_fresh_o  <= s1_i.fresh;
      checksum_ok_o    <= ok_d;
      command_length_o <= s1_i.length;
      sync_pulse_o     <= sync_d;
      bus_reset_o      <= busrst_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/core/i2c_slave_xor_checked_command.sv
// An accepted item is registered in the front stage, then in the output register of the back stage.
// Throughput: one item per cycle while the output is not stalled; the store takes one write and one read per cycle.
// The pop for a stop reads the store in the front stage; the read data is registered alongside the item.
// Reset (rst_ni, async, active low) clears counters, flags, XOR and reply state;
// store contents are not cleared, and config returns to address 104, ping code 0.
// ----------------------------------------------------------------------------
// i2c_slave_xor_checked_command
// I2C slave command front end: buffers command bytes with a running XOR,
// checks the trailing checksum on stop and serves a two-byte reply on reads after a good checksum.
// ----------------------------------------------------------------------------
module i2c_slave_xor_checked_command import i2cxc_pkg::*; #(
  parameter int unsigned STORE_DEPTH = DEFAULT_STORE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration write port
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  // input items
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] mode_i,
  input  logic [7:0] rx_byte_i,
  // result items
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] tx_byte_o,
  output logic       tx_valid_o,
  output logic       command_fresh_o,
  output logic       checksum_ok_o,
  output logic [5:0] command_length_o,
  output logic       sync_pulse_o,
  output logic       bus_reset_o
);

  localparam int unsigned AddrW = $clog2(STORE_DEPTH);

  // Config registers
  logic [6:0] node_address_q;
  logic [7:0] ping_code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_address_q <= NODE_ADDR_RST;
      ping_code_q    <= PING_CODE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NODE_ADDR: node_address_q <= cfg_wdata_i[6:0];
        CFG_PING_CODE: ping_code_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Pipeline handshake: the front stage holds one item while the back stage
  // (with its output register) is stalled; otherwise items flow every cycle.
  logic             acc;
  logic             adv;
  logic             s1_valid;
  s1_t              s1;
  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [7:0]       mem_rdata;

  assign in_stall_o = s1_valid && !adv;
  assign acc        = in_valid_i && !in_stall_o;

  // Front: count, flags, store addressing. Store writes and pop reads belong
  // to different items, so a pop always sees every earlier write: a write at
  // edge t is in the array before a read issued the cycle after.
  i2cxc_front #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .mode_i      (mode_i),
    .rx_byte_i   (rx_byte_i),
    .adv_i       (adv),
    .s1_valid_o  (s1_valid),
    .s1_o        (s1),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr)
  );

  // Command byte store; read data is held until the next pop is issued.
  i2cxc_store #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (rx_byte_i),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Back: XOR/checksum, reply bytes, result register.
  i2cxc_reply u_reply (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s1_valid_i       (s1_valid),
    .s1_i             (s1),
    .rdata_i          (mem_rdata),
    .node_address_i   (node_address_q),
    .ping_code_i      (ping_code_q),
    .out_stall_i      (out_stall_i),
    .adv_o            (adv),
    .out_valid_o      (out_valid_o),
    .tx_byte_o        (tx_byte_o),
    .tx_valid_o       (tx_valid_o),
    .command_fresh_o  (command_fresh_o),
    .checksum_ok_o    (checksum_ok_o),
    .command_length_o (command_length_o),
    .sync_pulse_o     (sync_pulse_o),
    .bus_reset_o      (bus_reset_o)
  );

`ifndef SYNTHESIS
  // A front item that advances lands in the output register at the next edge.
  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_o)
    else $error("front item advanced but no result");

  // Stop-only fields never show without command_fresh.
  a_fresh_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (checksum_ok_o || (command_length_o != 6'd0)) |-> command_fresh_o)
    else $error("checksum fields without command_fresh");

  // Each result stems from one event kind.
  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0({tx_valid_o, command_fresh_o, sync_pulse_o, bus_reset_o}))
    else $error("result flags from more than one event");

  // Input is stalled only while a front item is blocked.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid && out_valid_o && out_stall_i)
    else $error("input stalled without a blocked item");
`endif

endmodule
